// ===== design/lkss_pkg.sv =====
package lkss_pkg;

  // Table geometry.
  localparam int MAX_KEYS = 16;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int ID_W     = 32;
  localparam int RND_W    = 32;
  localparam int PROD_W   = RND_W + CNT_W;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;

  // Key type codes.
  localparam logic [1:0] KT_TEST = 2'd0;
  localparam logic [1:0] KT_PROD = 2'd1;
  localparam logic [1:0] KT_DEV  = 2'd2;

  // Life cycle state codes.
  localparam logic [2:0] LC_TEST     = 3'd0;
  localparam logic [2:0] LC_DEV      = 3'd1;
  localparam logic [2:0] LC_PROD     = 3'd2;
  localparam logic [2:0] LC_PROD_END = 3'd3;
  localparam logic [2:0] LC_RMA      = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_SCAN  = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_start;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_lookup;
    logic count_zero;
    logic scan_last;
  } dp_status_t;

  // True when the type and state codes are both legal.
  function automatic logic encoding_ok(input logic [1:0] ktype, input logic [2:0] lc);
    logic type_ok;
    logic lc_ok;
    type_ok = (ktype == KT_TEST) || (ktype == KT_PROD) || (ktype == KT_DEV);
    lc_ok   = (lc == LC_TEST) || (lc == LC_DEV) || (lc == LC_PROD) ||
              (lc == LC_PROD_END) || (lc == LC_RMA);
    return type_ok && lc_ok;
  endfunction

  // True when a key of this type may be used in this life cycle state.
  function automatic logic type_allowed(input logic [1:0] ktype, input logic [2:0] lc);
    logic ok;
    case (lc)
      LC_TEST:     ok = (ktype == KT_TEST) || (ktype == KT_PROD);
      LC_DEV:      ok = (ktype == KT_PROD) || (ktype == KT_DEV);
      LC_PROD:     ok = (ktype == KT_PROD);
      LC_PROD_END: ok = (ktype == KT_PROD);
      LC_RMA:      ok = (ktype == KT_TEST) || (ktype == KT_PROD);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== design/lkss_ctrl.sv =====
module lkss_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  lkss_pkg::dp_status_t   dp_status,
  output lkss_pkg::ctrl_cmd_t    ctrl_cmd
);

  lkss_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt           = state_r;
    ctrl_cmd.accept     = 1'b0;
    ctrl_cmd.load_start = 1'b0;
    ctrl_cmd.scan_step  = 1'b0;
    ctrl_cmd.load_out   = 1'b0;
    case (state_r)
      lkss_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl_cmd.accept = 1'b1;
          state_nxt = dp_status.in_is_lookup ? lkss_pkg::S_START : lkss_pkg::S_RESP;
        end
      end
      lkss_pkg::S_START: begin
        ctrl_cmd.load_start = 1'b1;
        state_nxt = dp_status.count_zero ? lkss_pkg::S_RESP : lkss_pkg::S_SCAN;
      end
      lkss_pkg::S_SCAN: begin
        ctrl_cmd.scan_step = 1'b1;
        if (dp_status.scan_last) begin
          state_nxt = lkss_pkg::S_RESP;
        end
      end
      lkss_pkg::S_RESP: begin
        if (out_free) begin
          ctrl_cmd.load_out = 1'b1;
          state_nxt = lkss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lkss_pkg::S_IDLE;
      end
    endcase
  end

  // Output valid flag is set by a load and cleared when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl_cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkss_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != lkss_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/lkss_dp.sv =====
module lkss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lkss_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          in_command,
  input  logic [3:0]                    in_entry_index,
  input  logic [31:0]                   in_key_id,
  input  logic [1:0]                    in_key_type,
  input  logic                          in_entry_enabled,
  input  logic [2:0]                    in_lc_state,
  input  logic [31:0]                   in_random_word,
  input  lkss_pkg::ctrl_cmd_t           ctrl_cmd,
  output lkss_pkg::dp_status_t          dp_status,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [3:0]                    out_selected_index
);

  localparam int IW = lkss_pkg::IDX_W;
  localparam int CW = lkss_pkg::CNT_W;

  // Key table; only the enabled bits have a reset value.
  logic [lkss_pkg::ID_W-1:0] slot_id_r   [lkss_pkg::MAX_KEYS];
  logic [1:0]                slot_type_r [lkss_pkg::MAX_KEYS];
  logic [lkss_pkg::MAX_KEYS-1:0] slot_en_r;

  logic [CW-1:0]              key_count_r;
  logic [CW-1:0]              count;
  logic [lkss_pkg::ID_W-1:0]  key_id_r;
  logic [2:0]                 lc_r;
  logic [lkss_pkg::RND_W-1:0] rnd_r;
  logic                       is_lookup_r;
  logic [IW-1:0]              idx_r, idx_nxt;
  logic [IW-1:0]              step_r;
  logic                       have_r, fault_r;
  logic [IW-1:0]              sel_r;
  logic [1:0]                 status_r;
  logic                       found_r;
  logic [IW-1:0]              out_idx_r;

  logic [lkss_pkg::PROD_W-1:0] prod;
  logic [IW-1:0]               start_idx;
  logic [CW-1:0]               idx_inc;
  logic [CW-1:0]               count_m1;
  logic                        cand;
  logic                        enc_ok;
  logic                        allowed;
  logic [IW-1:0]               wr_idx;
  logic [1:0]                  res_status;

  // Saturate the configured count to the table size.
  assign count = (key_count_r > CW'(lkss_pkg::MAX_KEYS)) ? CW'(lkss_pkg::MAX_KEYS)
                                                          : key_count_r;
  assign count_m1 = count - CW'(1);

  // Start slot is the top bits of random word times count.
  assign prod      = lkss_pkg::PROD_W'(rnd_r) * lkss_pkg::PROD_W'(count);
  assign start_idx = prod[lkss_pkg::RND_W +: IW];

  // Evaluate the slot under the scan pointer.
  assign cand    = (slot_id_r[idx_r] == key_id_r) && slot_en_r[idx_r];
  assign enc_ok  = lkss_pkg::encoding_ok(slot_type_r[idx_r], lc_r);
  assign allowed = lkss_pkg::type_allowed(slot_type_r[idx_r], lc_r);

  // Circular advance of the scan pointer.
  assign idx_inc = CW'(idx_r) + CW'(1);
  assign idx_nxt = (idx_inc >= count) ? '0 : idx_inc[IW-1:0];

  assign wr_idx = in_entry_index[IW-1:0];

  // Status to the controller.
  assign dp_status.in_is_lookup = (in_command == lkss_pkg::CMD_LOOKUP);
  assign dp_status.count_zero   = (count == '0);
  assign dp_status.scan_last    = (CW'(step_r) == count_m1);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= CW'(1);
    end else if (cfg_we) begin
      key_count_r <= cfg_wdata;
    end
  end

  // Table writes on an accepted write transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_en_r <= '0;
    end else if (ctrl_cmd.accept && (in_command == lkss_pkg::CMD_WRITE)) begin
      slot_en_r[wr_idx] <= in_entry_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.accept && (in_command == lkss_pkg::CMD_WRITE)) begin
      slot_id_r[wr_idx]   <= in_key_id;
      slot_type_r[wr_idx] <= in_key_type;
    end
  end

  // Lookup operands and scan state.
  always_ff @(posedge clk) begin
    if (ctrl_cmd.accept) begin
      key_id_r    <= in_key_id;
      lc_r        <= in_lc_state;
      rnd_r       <= in_random_word;
      is_lookup_r <= (in_command == lkss_pkg::CMD_LOOKUP);
      have_r      <= 1'b0;
      fault_r     <= 1'b0;
      sel_r       <= '0;
    end
    if (ctrl_cmd.load_start) begin
      idx_r  <= start_idx;
      step_r <= '0;
    end
    if (ctrl_cmd.scan_step) begin
      if (cand) begin
        if (!enc_ok) begin
          fault_r <= 1'b1;
        end else if (allowed) begin
          have_r <= 1'b1;
          sel_r  <= idx_r;
        end
      end
      idx_r  <= idx_nxt;
      step_r <= step_r + IW'(1);
    end
  end

  // Final result of the transaction.
  always_comb begin
    if (!is_lookup_r) begin
      res_status = lkss_pkg::ST_OK;
    end else if (fault_r) begin
      res_status = lkss_pkg::ST_FAULT;
    end else if (have_r) begin
      res_status = lkss_pkg::ST_OK;
    end else begin
      res_status = lkss_pkg::ST_BAD;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_out) begin
      status_r  <= res_status;
      found_r   <= is_lookup_r && have_r && !fault_r;
      out_idx_r <= (is_lookup_r && have_r && !fault_r) ? sel_r : '0;
    end
  end

  assign out_status         = status_r;
  assign out_found          = found_r;
  assign out_selected_index = 4'(out_idx_r);

endmodule

// ===== design/lifecycle_key_slot_selector_unit.sv =====
// Life cycle key slot selector.
// The input channel (in_valid / in_stall) carries one transaction per command:
// a table write (slot, identifier, type, enabled flag) or a key lookup
// (sought identifier, life cycle state, random word). Every transaction gives
// exactly one result on the output channel (out_valid / out_stall): status,
// found flag and selected slot. cfg_we with cfg_wdata sets the number of
// table entries in use; write it only while the block is idle.
// A write goes from acceptance straight to the result state and reaches the
// output register once that is free. A lookup computes its start slot, then
// visits one table entry per cycle through a single compare unit, key_count
// entries in all with key_count capped at 16, before its result is registered.
// One transaction is in flight at a time; the next one is accepted once the
// controller is back in idle after the current result is loaded.
// When the receiver stalls, the result holds in the output register and the
// block can accept and process one more transaction, then waits with its
// result and in_stall high until the register drains.
// Reset clears all enabled flags and sets the entry count to one; identifiers
// and types hold no value until written.
module lifecycle_key_slot_selector_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lkss_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [3:0]                 in_entry_index,
  input  logic [31:0]                in_key_id,
  input  logic [1:0]                 in_key_type,
  input  logic                       in_entry_enabled,
  input  logic [2:0]                 in_lc_state,
  input  logic [31:0]                in_random_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_found,
  output logic [3:0]                 out_selected_index
);

  lkss_pkg::ctrl_cmd_t  ctrl_cmd;
  lkss_pkg::dp_status_t dp_status;

  // Sequencing of each transaction.
  lkss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  // Key table, scan datapath and output register.
  lkss_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_key_id          (in_key_id),
    .in_key_type        (in_key_type),
    .in_entry_enabled   (in_entry_enabled),
    .in_lc_state        (in_lc_state),
    .in_random_word     (in_random_word),
    .ctrl_cmd           (ctrl_cmd),
    .dp_status          (dp_status),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_selected_index (out_selected_index)
  );

endmodule

// ===== design/lkss_checker.sv =====
module lkss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_found,
  input logic [3:0] out_selected_index
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found) &&
                               $stable(out_selected_index))
    else $error("stalled result changed");

  // Only one transaction is in flight: acceptance closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is in flight");

  // A selected key always comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == lkss_pkg::ST_OK)
    else $error("found key without ok status");

  // No selection reports slot zero and a defined status code.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_selected_index == 4'd0 &&
                                (out_status == lkss_pkg::ST_OK ||
                                 out_status == lkss_pkg::ST_BAD ||
                                 out_status == lkss_pkg::ST_FAULT))
    else $error("bad result without a selection");

endmodule

bind lifecycle_key_slot_selector_unit lkss_checker u_lkss_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_found          (out_found),
  .out_selected_index (out_selected_index)
);
